@@ sv/tts_pkg.sv @@
package tts_pkg;

	// Pitch step and volume limits.
	localparam logic [13:0] PITCH_MIN = 14'd100;
	localparam logic [13:0] PITCH_MAX = 14'd12000;
	localparam logic [7:0]  VOL_MAX   = 8'd255;
	localparam logic [9:0]  VOL_OFFSET = 10'd10;
	localparam logic [14:0] PITCH_OFFSET = 15'd400;

	// Reset values of the oscillator state and the registers.
	localparam logic [15:0] STEP_RESET        = 16'd100;
	localparam logic [6:0]  DEPTH_RESET       = 7'd0;
	localparam logic [9:0]  HALF_PERIOD_RESET = 10'd10;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_HALF_PERIOD = 2'd1;

	typedef struct packed {
		logic [6:0] mod_depth;
		logic [9:0] mod_half_period;
	} cfg_t;

	// Per-sample values derived from the light readings.
	typedef struct packed {
		logic [13:0] pitch;
		logic [7:0]  vol;
	} item_t;

	// clamp(10*(on-off)-400, 100, 12000)
	function automatic logic [13:0] pitch_calc(input logic [9:0] on, input logic [9:0] off);
		logic signed [14:0] d;
		logic signed [14:0] v;
		d = $signed({5'b0, on}) - $signed({5'b0, off});
		v = (d <<< 3) + (d <<< 1) - $signed(PITCH_OFFSET);
		if (v < $signed({1'b0, PITCH_MIN})) begin
			pitch_calc = PITCH_MIN;
		end else if (v > $signed({1'b0, PITCH_MAX})) begin
			pitch_calc = PITCH_MAX;
		end else begin
			pitch_calc = v[13:0];
		end
	endfunction

	// clamp(on-off-10, 0, 255)
	function automatic logic [7:0] vol_calc(input logic [9:0] on, input logic [9:0] off);
		logic signed [11:0] v;
		v = $signed({2'b0, on}) - $signed({2'b0, off}) - $signed({2'b0, VOL_OFFSET});
		if (v < 12'sd0) begin
			vol_calc = 8'd0;
		end else if (v > $signed({4'b0, VOL_MAX})) begin
			vol_calc = VOL_MAX;
		end else begin
			vol_calc = v[7:0];
		end
	endfunction

endpackage

@@ sv/tts_front.sv @@
module tts_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [9:0]          left_light_on,
	input  logic [9:0]          left_light_off,
	input  logic [9:0]          right_light_on,
	input  logic [9:0]          right_light_off,
	input  logic                take,
	output logic                valid_s1,
	output tts_pkg::item_t      item_s1
);

	logic accept;

	assign accept = in_valid && !in_stall;

	// Stage valid: set by an accepted beat, cleared when the oscillator takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Pitch step and volume are formed from the readings on the way in.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.pitch <= tts_pkg::pitch_calc(left_light_on, left_light_off);
			item_s1.vol   <= tts_pkg::vol_calc(right_light_on, right_light_off);
		end
	end

endmodule

@@ sv/tts_osc.sv @@
module tts_osc #(
	parameter int PHASE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  tts_pkg::item_t      item_s1,
	input  tts_pkg::cfg_t       cfg,
	input  logic                out_stall,
	output logic                take,
	output logic                out_valid,
	output logic [7:0]          sample
);

	localparam int SW = ((PHASE_BITS > 16) ? PHASE_BITS : 16) + 1;
	localparam logic [SW-1:0] PHASE_MAX = SW'((64'd1 << PHASE_BITS) - 64'd1);

	logic [PHASE_BITS-1:0] phase_q;
	logic                  rising_q;
	logic [15:0]           step_q;
	logic [10:0]           count_q;
	logic                  mod_up_q;

	logic [SW-1:0]         phase_x;
	logic [SW-1:0]         step_x;
	logic [SW-1:0]         sum_x;
	logic [SW-1:0]         diff_x;
	logic [PHASE_BITS-1:0] phase_d;
	logic                  rising_d;
	logic [10:0]           count_inc;
	logic [10:0]           count_d;
	logic [15:0]           step_d;
	logic                  mod_up_d;
	logic                  reload;
	logic [15:0]           pitch_x;
	logic [15:0]           depth_x;
	logic [15:0]           prod;

	// The output register loads whenever it is empty or being drained.
	assign take = valid_s1 && (!out_valid || !out_stall);

	// Phase advance with reflection at both ends.
	always_comb begin
		phase_x   = SW'(phase_q);
		step_x    = SW'(step_q);
		sum_x     = phase_x + step_x;
		diff_x    = step_x - phase_x;
		phase_d   = phase_q;
		rising_d  = rising_q;
		count_inc = count_q;
		if (!rising_q && (phase_x < step_x)) begin
			phase_d   = diff_x[PHASE_BITS-1:0];
			rising_d  = 1'b1;
			count_inc = count_q + 11'd1;
		end else if (rising_q && (sum_x > PHASE_MAX)) begin
			phase_d   = PHASE_MAX[PHASE_BITS-1:0] - sum_x[PHASE_BITS-1:0];
			rising_d  = 1'b0;
			count_inc = count_q + 11'd1;
		end else if (rising_q) begin
			phase_d   = sum_x[PHASE_BITS-1:0];
		end else begin
			phase_d   = phase_q - step_x[PHASE_BITS-1:0];
		end
	end

	// Vibrato reload once the reflection count passes the half period.
	always_comb begin
		pitch_x  = {2'b0, item_s1.pitch};
		depth_x  = {9'b0, cfg.mod_depth};
		reload   = count_inc > {1'b0, cfg.mod_half_period};
		step_d   = step_q;
		mod_up_d = mod_up_q;
		count_d  = count_inc;
		if (reload) begin
			count_d  = 11'd0;
			mod_up_d = !mod_up_q;
			if (!mod_up_q) begin
				step_d = pitch_x + depth_x;
			end else if (pitch_x > depth_x) begin
				step_d = pitch_x - depth_x;
			end else begin
				step_d = 16'd0;
			end
		end
	end

	assign prod = 16'(phase_d[PHASE_BITS-1 -: 8]) * 16'(item_s1.vol);

	// Oscillator state moves once per sample beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			rising_q <= 1'b1;
			step_q   <= tts_pkg::STEP_RESET;
			count_q  <= '0;
			mod_up_q <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_d;
			rising_q <= rising_d;
			step_q   <= step_d;
			count_q  <= count_d;
			mod_up_q <= mod_up_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample <= prod[15:8];
		end
	end

endmodule

@@ sv/triangle_tone_synth_from_light_sensors_top.sv @@
// Triangle tone synthesizer driven by four light readings per sample beat.
// Each beat is registered in the input stage and then in the output register.
// Throughput: one sample per cycle while out_stall is low; the phase update and sample multiply share one stage.
// Reset (arst_n low) clears the phase, sets the direction upward, the active step to 100,
// the vibrato depth to 0 and the half period to 10.
module triangle_tone_synth_from_light_sensors_top #(
	parameter int PHASE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [9:0]                      left_light_on,
	input  logic [9:0]                      left_light_off,
	input  logic [9:0]                      right_light_on,
	input  logic [9:0]                      right_light_off,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      sample,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tts_pkg::CFG_DATA_W-1:0]  cfg_data
);

	tts_pkg::cfg_t  cfg_q;
	tts_pkg::item_t item_s1;
	logic           valid_s1;
	logic           take;

	assign cfg_ready = 1'b1;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mod_depth       <= tts_pkg::DEPTH_RESET;
			cfg_q.mod_half_period <= tts_pkg::HALF_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tts_pkg::REG_MOD_DEPTH: begin
					cfg_q.mod_depth <= cfg_data[6:0];
				end
				tts_pkg::REG_MOD_HALF_PERIOD: begin
					cfg_q.mod_half_period <= cfg_data[9:0];
				end
				default: begin
				end
			endcase
		end
	end

	// A new beat waits only while the input stage is full and cannot move on.
	assign in_stall = valid_s1 && !take;

	tts_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.left_light_on   (left_light_on),
		.left_light_off  (left_light_off),
		.right_light_on  (right_light_on),
		.right_light_off (right_light_off),
		.take            (take),
		.valid_s1        (valid_s1),
		.item_s1         (item_s1)
	);

	tts_osc #(
		.PHASE_BITS (PHASE_BITS)
	) u_osc (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.cfg       (cfg_q),
		.out_stall (out_stall),
		.take      (take),
		.out_valid (out_valid),
		.sample    (sample)
	);

endmodule

@@ tb/triangle_tone_synth_from_light_sensors_top_tb.sv @@
`timescale 1ns / 1ps

module triangle_tone_synth_from_light_sensors_top_tb;

	// Oscillator and clamp constants, taken as plain integers.
	localparam int PITCH_LO = int'(tts_pkg::PITCH_MIN);
	localparam int PITCH_HI = int'(tts_pkg::PITCH_MAX);
	localparam int PITCH_OFFSET = int'(tts_pkg::PITCH_OFFSET);
	localparam int VOL_HI = int'(tts_pkg::VOL_MAX);
	localparam int VOL_OFFSET = int'(tts_pkg::VOL_OFFSET);
	localparam int PHASE_MAX = 65535;
	localparam int BOUNCE_MASK = 'h7FF;
	localparam int DEPTH_MASK = 'h7F;
	localparam int QUIET_LIMIT = 2000;

	// Register indexes that decode to nothing.
	localparam logic [tts_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [tts_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic [9:0] left_on;
		logic [9:0] left_off;
		logic [9:0] right_on;
		logic [9:0] right_off;
	} reading_t;

	typedef enum {
		READ_TONAL,
		READ_WILD,
		READ_LOW_PITCH
	} reading_kind_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [9:0] left_light_on = '0;
	logic [9:0] left_light_off = '0;
	logic [9:0] right_light_on = '0;
	logic [9:0] right_light_off = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] sample;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tts_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int gap_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int quiet_cycles = 0;
	logic [7:0] expected_samples [$];

	// Shadow of the oscillator state and the vibrato registers.
	int tone_phase;
	bit tone_rising;
	int tone_step;
	int bounce_count;
	bit vibrato_up;
	int vib_depth;
	int vib_half_period;

	triangle_tone_synth_from_light_sensors_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.left_light_on(left_light_on),
		.left_light_off(left_light_off),
		.right_light_on(right_light_on),
		.right_light_off(right_light_off),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample(sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic reset_shadow();
		tone_phase = 0;
		tone_rising = 1'b1;
		tone_step = int'(tts_pkg::STEP_RESET);
		bounce_count = 0;
		vibrato_up = 1'b0;
		vib_depth = int'(tts_pkg::DEPTH_RESET);
		vib_half_period = int'(tts_pkg::HALF_PERIOD_RESET);
	endtask

	// Advance the shadow oscillator by one tick and return the sample it yields.
	function automatic logic [7:0] predict_sample(input reading_t r);
		int pitch;
		int vol;
		int level;
		pitch = (int'(r.left_on) - int'(r.left_off)) * 10 - PITCH_OFFSET;
		if (pitch < PITCH_LO) begin
			pitch = PITCH_LO;
		end else if (pitch > PITCH_HI) begin
			pitch = PITCH_HI;
		end
		vol = int'(r.right_on) - int'(r.right_off) - VOL_OFFSET;
		if (vol < 0) begin
			vol = 0;
		end else if (vol > VOL_HI) begin
			vol = VOL_HI;
		end

		// Move the phase, reflecting off the bottom and the top.
		if (!tone_rising && tone_phase < tone_step) begin
			tone_phase = (tone_step - tone_phase) & PHASE_MAX;
			tone_rising = 1'b1;
			bounce_count++;
		end else if (tone_rising && tone_phase + tone_step > PHASE_MAX) begin
			tone_phase = PHASE_MAX - ((tone_phase + tone_step) & PHASE_MAX);
			tone_rising = 1'b0;
			bounce_count++;
		end else if (tone_rising) begin
			tone_phase = (tone_phase + tone_step) & PHASE_MAX;
		end else begin
			tone_phase = (tone_phase - tone_step) & PHASE_MAX;
		end
		bounce_count &= BOUNCE_MASK;

		level = tone_phase >> 8;
		predict_sample = 8'((level * vol) >> 8);

		// Vibrato reload alternates between pitch plus depth and pitch minus depth.
		if (bounce_count > vib_half_period) begin
			if (!vibrato_up) begin
				vibrato_up = 1'b1;
				tone_step = (pitch + vib_depth) & PHASE_MAX;
			end else begin
				vibrato_up = 1'b0;
				tone_step = (pitch > vib_depth) ? pitch - vib_depth : 0;
			end
			bounce_count = 0;
		end
	endfunction

	// Receiver stall pattern, redrawn every cycle.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Compare each sample beat against the oldest expectation.
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected sample beat, expected none, got %0d", $time, sample);
				errors++;
			end else begin
				want = expected_samples.pop_front();
				if (sample !== want) begin
					$display("%0t: sample mismatch, expected %0d, got %0d",
						$time, want, sample);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles in which no channel moves a beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic set_pace(input int gap, input int stall);
		gap_pct = gap;
		stall_pct = stall;
	endtask

	// Write one register; valid drops before any following write.
	task automatic write_reg(input logic [tts_pkg::CFG_IDX_W-1:0] idx,
			input logic [tts_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == tts_pkg::REG_MOD_DEPTH) begin
			vib_depth = int'(data) & DEPTH_MASK;
		end else if (idx == tts_pkg::REG_MOD_HALF_PERIOD) begin
			vib_half_period = int'(data);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_vibrato(input int depth, input int half_period);
		write_reg(tts_pkg::REG_MOD_DEPTH, 10'(depth));
		write_reg(tts_pkg::REG_MOD_HALF_PERIOD, 10'(half_period));
	endtask

	// Send one reading beat; valid stays high on return so the next beat can follow.
	task automatic send_reading(input reading_t r);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		left_light_on <= r.left_on;
		left_light_off <= r.left_off;
		right_light_on <= r.right_on;
		right_light_off <= r.right_off;
		do @(posedge clk); while (in_stall !== 1'b0);
		expected_samples.push_back(predict_sample(r));
		@(negedge clk);
	endtask

	// Wait until every expected sample has arrived, plus a little slack.
	task automatic drain();
		while (expected_samples.size() != 0) begin
			@(negedge clk);
		end
		repeat (6) @(negedge clk);
	endtask

	function automatic reading_t make_reading(input reading_kind_t kind);
		reading_t r;
		r.right_off = 10'($urandom_range(1023));
		r.right_on = 10'($urandom_range(1023, int'(r.right_off)));
		if ($urandom_range(99) < 20) begin
			r.right_on = 10'($urandom_range(1023));
		end
		case (kind)
			READ_TONAL: begin
				// Keep the pitch step well above the vibrato depth.
				r.left_off = 10'($urandom_range(883));
				r.left_on = 10'($urandom_range(1023, int'(r.left_off) + 140));
			end
			READ_LOW_PITCH: begin
				r.left_on = 10'($urandom_range(1023));
				r.left_off = 10'($urandom_range(1023, int'(r.left_on)));
			end
			default: begin
				r.left_on = 10'($urandom_range(1023));
				r.left_off = 10'($urandom_range(1023));
				r.right_on = 10'($urandom_range(1023));
				r.right_off = 10'($urandom_range(1023));
			end
		endcase
		return r;
	endfunction

	task automatic stream_readings(input int count, input reading_kind_t kind);
		for (int i = 0; i < count; i++) begin
			send_reading(make_reading(kind));
		end
		in_valid <= 1'b0;
		drain();
	endtask

	// Reading corners under the reset settings: clamps at both ends, negative
	// differences, and alternating bit patterns. The pitch ceiling lies above
	// what ten-bit readings can reach.
	task automatic test_reading_extremes();
		reading_t corners [18];
		corners = '{
			'{10'd0, 10'd0, 10'd0, 10'd0},
			'{10'd1023, 10'd1023, 10'd1023, 10'd1023},
			'{10'd1023, 10'd0, 10'd1023, 10'd0},
			'{10'd0, 10'd1023, 10'd0, 10'd1023},
			'{10'd512, 10'd462, 10'd300, 10'd290},
			'{10'd512, 10'd461, 10'd300, 10'd289},
			'{10'd512, 10'd463, 10'd300, 10'd291},
			'{10'd700, 10'd100, 10'd400, 10'd135},
			'{10'd700, 10'd99, 10'd400, 10'd134},
			'{10'd700, 10'd101, 10'd400, 10'd136},
			'{10'd1023, 10'd1, 10'd1022, 10'd0},
			'{10'd341, 10'd682, 10'd682, 10'd341},
			'{10'd682, 10'd341, 10'd341, 10'd682},
			'{10'd1, 10'd0, 10'd11, 10'd0},
			'{10'd0, 10'd1, 10'd0, 10'd1},
			'{10'd1023, 10'd1022, 10'd265, 10'd0},
			'{10'd512, 10'd512, 10'd512, 10'd512},
			'{10'd100, 10'd50, 10'd500, 10'd250}
		};
		set_pace(0, 0);
		foreach (corners[i]) begin
			send_reading(corners[i]);
		end
		in_valid <= 1'b0;
		drain();
	endtask

	// Slow ramp at the reset step up to the first reflection, then a reload
	// on every reflection with no depth.
	task automatic test_first_reflection();
		set_pace(0, 0);
		set_vibrato(0, 0);
		stream_readings(700, READ_TONAL);
	endtask

	// Deep vibrato (depth 99) with a reload on every reflection.
	task automatic test_deep_vibrato();
		set_pace(47, 0);
		set_vibrato(99, 0);
		stream_readings(300, READ_TONAL);
	endtask

	// Longest half period, so no reload; readings span the whole field range.
	// Writes to the unused indexes must change nothing.
	task automatic test_long_half_period();
		set_pace(0, 47);
		write_reg(REG_SPARE_2, 10'($urandom_range(1023)));
		write_reg(REG_SPARE_3, 10'($urandom_range(1023)));
		set_vibrato(1, 1023);
		stream_readings(250, READ_WILD);
	endtask

	// Several random settings with short half periods.
	task automatic test_mixed_settings();
		set_pace(24, 24);
		for (int round = 0; round < 3; round++) begin
			set_vibrato($urandom_range(99), $urandom_range(12, 1));
			stream_readings(100, READ_TONAL);
		end
	endtask

	// Depth above the minimum pitch step: the minus reload saturates the step
	// at zero and the phase then stands still. This runs last since the
	// oscillator cannot leave that state.
	task automatic test_zero_step();
		set_pace(0, 0);
		write_reg(tts_pkg::REG_MOD_DEPTH, 10'h3FF);
		write_reg(tts_pkg::REG_MOD_HALF_PERIOD, 10'd0);
		stream_readings(400, READ_LOW_PITCH);
	endtask

	initial begin
		reset_shadow();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reading_extremes();
		test_first_reflection();
		test_deep_vibrato();
		test_long_half_period();
		test_mixed_settings();
		test_zero_step();

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
